>>> src/smrd_pkg.sv
// Shared constants, codes and types for the sync-marker record deframer.
// Used by every module in src; depends on nothing.
`default_nettype none

package smrd_pkg;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int STAMP_W  = 64;
    localparam int DIGEST_W = 64;
    localparam int LEN_W    = 32;
    localparam int PHASE_W  = 3;
    localparam int COUNT_W  = 3;

    // Output tdata: stamp, digest, payload_length, payload_byte from bit 0 up.
    localparam int M_DATA_W = STAMP_W + DIGEST_W + LEN_W + BYTE_W;

    localparam logic [BYTE_W-1:0] MARK0 = 8'hE2;
    localparam logic [BYTE_W-1:0] MARK1 = 8'h98;
    localparam logic [BYTE_W-1:0] MARK2 = 8'hA2;

    localparam logic [LEN_W-1:0] HEADER_BYTES = 32'd16;

    localparam logic [PHASE_W-1:0] PH_HUNT0   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HUNT1   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HUNT2   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SIZE    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_STAMP   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DIGEST  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd6;

    localparam logic [COUNT_W-1:0] SIZE_LAST_IDX = 3'd3;
    localparam logic [COUNT_W-1:0] WORD_LAST_IDX = 3'd7;

    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_LEN = 2'd2;

    typedef struct packed {
        logic                valid;
        logic [KIND_W-1:0]   kind;
        logic [STAMP_W-1:0]  stamp;
        logic [DIGEST_W-1:0] digest;
        logic [LEN_W-1:0]    payload_length;
        logic [BYTE_W-1:0]   payload_byte;
        logic                last;
    } smrd_result_t;

endpackage

`default_nettype wire

>>> src/sync_marker_record_deframer_unit.sv
// Sync-marker record deframer: one input byte per cycle, at most one result per cycle.
// Path: an accepted byte is held in the input register, parsed, and its result is
// loaded into the result register that drives m_*.
// Throughput: one byte per cycle, with a combinational parse step between
// the input register and the result register; stalls only on m_tready low.
// Reset: synchronous, active-low aresetn clears the parse state (hunting the
// first marker byte) and both stage valids.
`default_nettype none

module sync_marker_record_deframer_unit (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [smrd_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] data_byte
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // [63:0] stamp, [127:64] digest, [159:128] payload_length,
    // [167:160] payload_byte
    output logic [smrd_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [smrd_pkg::KIND_W-1:0]        m_tuser,   // [1:0] kind
    output logic                               m_tlast
);

    logic                          in_valid_reg, in_valid_next;
    logic [smrd_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                          out_free;
    logic                          advance;
    smrd_pkg::smrd_result_t        result;

    // A held byte is consumed whenever the result register can take its result.
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    smrd_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance_i (advance),
        .byte_i    (in_byte_reg),
        .result_o  (result)
    );

    smrd_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_i   (advance && result.valid),
        .result_i (result),
        .free_o   (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> src/smrd_parse.sv
// Frame parser: marker hunt, header field gathering and payload count.
// Holds the parse state and forms at most one result per consumed byte.
// Depends on smrd_pkg.
`default_nettype none

module smrd_parse (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                advance_i,
    input  wire  [smrd_pkg::BYTE_W-1:0]        byte_i,
    output smrd_pkg::smrd_result_t             result_o
);

    logic [smrd_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [smrd_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [smrd_pkg::LEN_W-1:0]    size_reg, size_next;
    logic [smrd_pkg::STAMP_W-1:0]  stamp_reg, stamp_next;
    logic [smrd_pkg::DIGEST_W-1:0] digest_reg, digest_next;
    logic [smrd_pkg::LEN_W-1:0]    left_reg, left_next;

    logic [63:0]                   placed;
    logic [smrd_pkg::LEN_W-1:0]    size_new;
    logic [smrd_pkg::DIGEST_W-1:0] digest_new;
    logic [smrd_pkg::LEN_W-1:0]    plen;
    logic [smrd_pkg::LEN_W-1:0]    left_dec;

    // The incoming byte moved to the lane picked by the field byte index.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            placed[i*8 +: 8] = (count_reg == 3'(i)) ? byte_i : 8'h00;
        end
    end

    assign size_new   = size_reg | placed[smrd_pkg::LEN_W-1:0];
    assign digest_new = digest_reg | placed;
    assign plen       = size_reg - smrd_pkg::HEADER_BYTES;
    assign left_dec   = left_reg - 32'd1;

    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        size_next   = size_reg;
        stamp_next  = stamp_reg;
        digest_next = digest_reg;
        left_next   = left_reg;
        result_o    = '0;

        case (phase_reg)
            smrd_pkg::PH_HUNT1: begin
                phase_next = (byte_i == smrd_pkg::MARK1) ? smrd_pkg::PH_HUNT2
                                                         : smrd_pkg::PH_HUNT0;
            end
            smrd_pkg::PH_HUNT2: begin
                if (byte_i == smrd_pkg::MARK2) begin
                    phase_next = smrd_pkg::PH_SIZE;
                    count_next = '0;
                    size_next  = '0;
                end else begin
                    phase_next = smrd_pkg::PH_HUNT0;
                end
            end
            smrd_pkg::PH_SIZE: begin
                size_next = size_new;
                if (count_reg >= smrd_pkg::SIZE_LAST_IDX) begin
                    count_next = '0;
                    if (size_new[smrd_pkg::LEN_W-1:4] == '0) begin
                        // Too short to hold the stamp and hash: drop the record.
                        phase_next      = smrd_pkg::PH_HUNT0;
                        result_o.valid  = 1'b1;
                        result_o.kind   = smrd_pkg::KIND_BAD_LEN;
                    end else begin
                        phase_next = smrd_pkg::PH_STAMP;
                        stamp_next = '0;
                    end
                end else begin
                    count_next = count_reg + 3'd1;
                end
            end
            smrd_pkg::PH_STAMP: begin
                stamp_next = stamp_reg | placed;
                if (count_reg >= smrd_pkg::WORD_LAST_IDX) begin
                    count_next  = '0;
                    phase_next  = smrd_pkg::PH_DIGEST;
                    digest_next = '0;
                end else begin
                    count_next = count_reg + 3'd1;
                end
            end
            smrd_pkg::PH_DIGEST: begin
                digest_next = digest_new;
                if (count_reg >= smrd_pkg::WORD_LAST_IDX) begin
                    count_next = '0;
                    left_next  = plen;
                    phase_next = (plen == '0) ? smrd_pkg::PH_HUNT0
                                              : smrd_pkg::PH_PAYLOAD;
                    result_o.valid          = 1'b1;
                    result_o.kind           = smrd_pkg::KIND_HEADER;
                    result_o.stamp          = stamp_reg;
                    result_o.digest         = digest_new;
                    result_o.payload_length = plen;
                    result_o.last           = (plen == '0);
                end else begin
                    count_next = count_reg + 3'd1;
                end
            end
            smrd_pkg::PH_PAYLOAD: begin
                if (left_reg == '0) begin
                    count_next = '0;
                    phase_next = (byte_i == smrd_pkg::MARK0) ? smrd_pkg::PH_HUNT1
                                                             : smrd_pkg::PH_HUNT0;
                end else begin
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        phase_next = smrd_pkg::PH_HUNT0;
                        count_next = '0;
                    end
                    result_o.valid        = 1'b1;
                    result_o.kind         = smrd_pkg::KIND_PAYLOAD;
                    result_o.payload_byte = byte_i;
                    result_o.last         = (left_dec == '0);
                end
            end
            default: begin
                phase_next = (byte_i == smrd_pkg::MARK0) ? smrd_pkg::PH_HUNT1
                                                         : smrd_pkg::PH_HUNT0;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= smrd_pkg::PH_HUNT0;
            count_reg  <= '0;
            size_reg   <= '0;
            stamp_reg  <= '0;
            digest_reg <= '0;
            left_reg   <= '0;
        end else if (advance_i) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            size_reg   <= size_next;
            stamp_reg  <= stamp_next;
            digest_reg <= digest_next;
            left_reg   <= left_next;
        end
    end

    // A dropped record always sends the parser back to the hunt.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance_i && result_o.valid && result_o.kind == smrd_pkg::KIND_BAD_LEN)
        |=> phase_reg == smrd_pkg::PH_HUNT0)
        else $error("bad length result did not restart the hunt");

    // The final payload byte of a record ends the payload phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance_i && result_o.valid && result_o.kind == smrd_pkg::KIND_PAYLOAD
         && result_o.last) |=> phase_reg == smrd_pkg::PH_HUNT0)
        else $error("payload phase continued past the last byte");

    // The payload phase is only entered with bytes left to count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == smrd_pkg::PH_PAYLOAD) |-> (left_reg != '0))
        else $error("payload phase with an empty byte count");

    // The size field is four bytes long.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == smrd_pkg::PH_SIZE) |-> (count_reg <= smrd_pkg::SIZE_LAST_IDX))
        else $error("size byte index out of range");

endmodule

`default_nettype wire

>>> src/smrd_out_reg.sv
// Result register that drives the master-side stream.
// Holds one result until the downstream side takes it. Depends on smrd_pkg.
`default_nettype none

module smrd_out_reg (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                load_i,
    input  wire  smrd_pkg::smrd_result_t       result_i,
    output logic                               free_o,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [smrd_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [smrd_pkg::KIND_W-1:0]        m_tuser,
    output logic                               m_tlast
);

    logic                   valid_reg, valid_next;
    smrd_pkg::smrd_result_t res_reg;

    assign free_o = !valid_reg || m_tready;

    always_comb begin
        if (load_i) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            res_reg <= result_i;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.payload_byte, res_reg.payload_length,
                       res_reg.digest, res_reg.stamp};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

endmodule

`default_nettype wire

>>> tb/tb_sync_marker_record_deframer_unit.sv
// Self-checking testbench for sync_marker_record_deframer_unit: byte stream in, parsed
// header, payload and bad-length results out, predicted per byte and compared in order.
// Depends on smrd_pkg and the rest of the RTL in src.
module tb_sync_marker_record_deframer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_GOAL    = 1350;
    localparam int QUIET_ITEMS  = 250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;

    // Offsets of the result fields inside m_tdata.
    localparam int DIGEST_LO = smrd_pkg::STAMP_W;
    localparam int LEN_LO    = smrd_pkg::STAMP_W + smrd_pkg::DIGEST_W;
    localparam int PBYTE_LO  = LEN_LO + smrd_pkg::LEN_W;

    typedef struct {
        logic [smrd_pkg::KIND_W-1:0]   kind;
        logic [smrd_pkg::STAMP_W-1:0]  stamp;
        logic [smrd_pkg::DIGEST_W-1:0] digest;
        logic [smrd_pkg::LEN_W-1:0]    payload_length;
        logic [smrd_pkg::BYTE_W-1:0]   payload_byte;
        logic                          last;
    } record_result_t;

    // Tracks the parse state of the byte stream and holds the results it implies.
    class record_tracker;
        logic [smrd_pkg::PHASE_W-1:0]  phase;
        logic [smrd_pkg::COUNT_W-1:0]  field_count;
        logic [smrd_pkg::LEN_W-1:0]    size_acc;
        logic [smrd_pkg::STAMP_W-1:0]  stamp_acc;
        logic [smrd_pkg::DIGEST_W-1:0] digest_acc;
        logic [smrd_pkg::LEN_W-1:0]    payload_left;
        record_result_t                due_results[$];
        int                            mismatches;

        function new();
            phase        = smrd_pkg::PH_HUNT0;
            field_count  = '0;
            size_acc     = '0;
            stamp_acc    = '0;
            digest_acc   = '0;
            payload_left = '0;
            mismatches   = 0;
        endfunction

        function void note_byte(logic [smrd_pkg::BYTE_W-1:0] b);
            record_result_t r;
            logic [5:0]     sh;
            logic [smrd_pkg::LEN_W-1:0] plen;
            bit             produced;
            produced = 1'b0;
            sh = {field_count, 3'b000};
            r.kind = smrd_pkg::KIND_HEADER;
            r.stamp = '0;
            r.digest = '0;
            r.payload_length = '0;
            r.payload_byte = '0;
            r.last = 1'b0;
            case (phase)
                smrd_pkg::PH_HUNT1: begin
                    phase = (b == smrd_pkg::MARK1) ? smrd_pkg::PH_HUNT2 : smrd_pkg::PH_HUNT0;
                end
                smrd_pkg::PH_HUNT2: begin
                    if (b == smrd_pkg::MARK2) begin
                        phase = smrd_pkg::PH_SIZE;
                        field_count = '0;
                        size_acc = '0;
                    end else begin
                        phase = smrd_pkg::PH_HUNT0;
                    end
                end
                smrd_pkg::PH_SIZE: begin
                    size_acc = size_acc | ({24'b0, b} << sh[4:0]);
                    if (field_count >= smrd_pkg::SIZE_LAST_IDX) begin
                        field_count = '0;
                        if (size_acc < smrd_pkg::HEADER_BYTES) begin
                            // Too short to hold stamp and digest: drop the record.
                            phase = smrd_pkg::PH_HUNT0;
                            r.kind = smrd_pkg::KIND_BAD_LEN;
                            produced = 1'b1;
                        end else begin
                            phase = smrd_pkg::PH_STAMP;
                            stamp_acc = '0;
                        end
                    end else begin
                        field_count = field_count + 1'b1;
                    end
                end
                smrd_pkg::PH_STAMP: begin
                    stamp_acc = stamp_acc | ({56'b0, b} << sh);
                    if (field_count >= smrd_pkg::WORD_LAST_IDX) begin
                        field_count = '0;
                        phase = smrd_pkg::PH_DIGEST;
                        digest_acc = '0;
                    end else begin
                        field_count = field_count + 1'b1;
                    end
                end
                smrd_pkg::PH_DIGEST: begin
                    digest_acc = digest_acc | ({56'b0, b} << sh);
                    if (field_count >= smrd_pkg::WORD_LAST_IDX) begin
                        plen = size_acc - smrd_pkg::HEADER_BYTES;
                        field_count = '0;
                        payload_left = plen;
                        phase = (plen == '0) ? smrd_pkg::PH_HUNT0 : smrd_pkg::PH_PAYLOAD;
                        r.kind = smrd_pkg::KIND_HEADER;
                        r.stamp = stamp_acc;
                        r.digest = digest_acc;
                        r.payload_length = plen;
                        r.last = (plen == '0);
                        produced = 1'b1;
                    end else begin
                        field_count = field_count + 1'b1;
                    end
                end
                smrd_pkg::PH_PAYLOAD: begin
                    if (payload_left == '0) begin
                        field_count = '0;
                        phase = (b == smrd_pkg::MARK0) ? smrd_pkg::PH_HUNT1
                                                       : smrd_pkg::PH_HUNT0;
                    end else begin
                        payload_left = payload_left - 1'b1;
                        if (payload_left == '0) begin
                            phase = smrd_pkg::PH_HUNT0;
                            field_count = '0;
                        end
                        r.kind = smrd_pkg::KIND_PAYLOAD;
                        r.payload_byte = b;
                        r.last = (payload_left == '0);
                        produced = 1'b1;
                    end
                end
                default: begin
                    phase = (b == smrd_pkg::MARK0) ? smrd_pkg::PH_HUNT1 : smrd_pkg::PH_HUNT0;
                    field_count = '0;
                end
            endcase
            if (produced) due_results.push_back(r);
        endfunction

        function void compare_field(string fname, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in %s: expected %h, got %h", fname, want, got);
            end
        endfunction

        function void check_result(logic [smrd_pkg::KIND_W-1:0] kind,
                                   logic [smrd_pkg::M_DATA_W-1:0] data, logic last);
            record_result_t r;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %h, data %h, last %b", kind, data, last);
            end else begin
                r = due_results.pop_front();
                compare_field("kind", 64'(r.kind), 64'(kind));
                compare_field("stamp", r.stamp, data[smrd_pkg::STAMP_W-1:0]);
                compare_field("digest", r.digest, data[DIGEST_LO +: smrd_pkg::DIGEST_W]);
                compare_field("payload_length", 64'(r.payload_length),
                              64'(data[LEN_LO +: smrd_pkg::LEN_W]));
                compare_field("payload_byte", 64'(r.payload_byte),
                              64'(data[PBYTE_LO +: smrd_pkg::BYTE_W]));
                compare_field("last", 64'(r.last), 64'(last));
            end
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    wire                             s_tready;
    logic [smrd_pkg::BYTE_W-1:0]     s_tdata = '0;
    wire                             m_tvalid;
    logic                            m_tready = 1'b0;
    wire  [smrd_pkg::M_DATA_W-1:0]   m_tdata;
    wire  [smrd_pkg::KIND_W-1:0]     m_tuser;
    wire                             m_tlast;

    record_tracker sb;
    bit  tx_idle_en = 1'b0;
    bit  rx_idle_en = 1'b0;
    int  rx_hold = 0;
    int  cycle_count = 0;
    int  record_items = 0;

    sync_marker_record_deframer_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Receiver back-pressure in short random bursts.
    always @(posedge aclk) begin
        if (!rx_idle_en) begin
            m_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            rx_hold = $urandom_range(1, 4) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Signals only change at the rising edge, so the falling edge sees settled values
    // for the request that completes at the next rising edge.
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_sync_marker_record_deframer_unit: FAIL");
        $finish;
    end

    // Called at a rising edge; returns at the rising edge where the byte is taken.
    task automatic send_byte(input logic [smrd_pkg::BYTE_W-1:0] b);
        int gap;
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(negedge aclk); while (!s_tready);
        sb.note_byte(b);
        record_items++;
        @(posedge aclk);
    endtask

    task automatic send_record(input logic [smrd_pkg::LEN_W-1:0] size);
        int i;
        send_byte(smrd_pkg::MARK0);
        send_byte(smrd_pkg::MARK1);
        send_byte(smrd_pkg::MARK2);
        for (i = 0; i < 4; i++) send_byte(size[8*i +: 8]);
        if (size >= smrd_pkg::HEADER_BYTES) begin
            for (i = 0; i < 16; i++) send_byte(8'($urandom));
            for (i = 0; i < int'(size - smrd_pkg::HEADER_BYTES); i++)
                send_byte(8'($urandom));
        end
    endtask

    // Junk between records, often a marker that breaks off.
    task automatic send_noise();
        int n;
        int i;
        case ($urandom_range(0, 3))
            0: send_byte(smrd_pkg::MARK0);
            1: begin
                send_byte(smrd_pkg::MARK0);
                send_byte(smrd_pkg::MARK1);
            end
            2: begin
                send_byte(smrd_pkg::MARK0);
                send_byte(smrd_pkg::MARK1);
                send_byte(8'($urandom));
            end
            default: begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) send_byte(8'($urandom));
            end
        endcase
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() > 0) @(posedge aclk);
    endtask

    initial begin
        logic [smrd_pkg::BYTE_W-1:0] directed[];
        logic [smrd_pkg::LEN_W-1:0] size;
        int pick;
        bit drained_once;
        directed = '{
            // Second marker byte wrong: the repeated first byte is not retried.
            smrd_pkg::MARK0, smrd_pkg::MARK0, smrd_pkg::MARK1, smrd_pkg::MARK2,
            8'h00, 8'hFF,
            // Third marker byte wrong.
            smrd_pkg::MARK0, smrd_pkg::MARK1, 8'h00,
            // Size zero, then size fifteen: both are too short.
            smrd_pkg::MARK0, smrd_pkg::MARK1, smrd_pkg::MARK2, 8'h00, 8'h00, 8'h00, 8'h00,
            smrd_pkg::MARK0, smrd_pkg::MARK1, smrd_pkg::MARK2, 8'h0F, 8'h00, 8'h00, 8'h00
        };
        drained_once = 1'b0;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[k]) send_byte(directed[k]);

        while (record_items < ITEM_GOAL) begin
            if (record_items > ITEM_GOAL - QUIET_ITEMS) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                pick = $urandom_range(0, 3);
                tx_idle_en = pick[0];
                rx_idle_en = pick[1];
            end
            if (!drained_once && record_items > ITEM_GOAL / 2) begin
                hold_until_drained();
                drained_once = 1'b1;
            end
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                if ($urandom_range(0, 24) == 0)
                    size = smrd_pkg::HEADER_BYTES + $urandom_range(200, 300);
                else if ($urandom_range(0, 4) == 0)
                    size = smrd_pkg::HEADER_BYTES;
                else
                    size = smrd_pkg::HEADER_BYTES + $urandom_range(1, 24);
                send_record(size);
            end else if (pick < 16) begin
                send_record($urandom_range(0, 15));
            end else begin
                send_noise();
            end
        end

        s_tvalid <= 1'b0;
        while (sb.outstanding() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("tb_sync_marker_record_deframer_unit: PASS");
        end else begin
            $display("tb_sync_marker_record_deframer_unit: FAIL");
        end
        $finish;
    end
endmodule

>>> files.f
src/smrd_pkg.sv
src/smrd_parse.sv
src/smrd_out_reg.sv
src/sync_marker_record_deframer_unit.sv
tb/tb_sync_marker_record_deframer_unit.sv
